// ===== rtl/pid_pkg.sv =====
`default_nettype none

package pid_pkg;

    localparam int unsigned PID_QUEUE_DEPTH = 32;
    localparam int unsigned PID_MAX_RESULTS = 32;
    localparam int unsigned PID_TAKEN_W     = $clog2(PID_MAX_RESULTS + 1);
    localparam int unsigned PID_CFG_IDX_W   = 2;
    localparam int unsigned PID_CFG_DATA_W  = 16;

    // Lag at or below this goes straight out without queuing
    localparam logic [15:0] PID_LAG_IMMEDIATE_MAX = 16'd100;

    typedef enum logic [0:0] {
        CMD_SEND = 1'b0,
        CMD_TICK = 1'b1
    } pid_cmd_t;

    typedef enum logic [0:0] {
        STATUS_SENT    = 1'b0,
        STATUS_DROPPED = 1'b1
    } pid_status_t;

    typedef enum logic [PID_CFG_IDX_W-1:0] {
        CFG_LAG       = 2'd0,
        CFG_LOSS      = 2'd1,
        CFG_DUPLICATE = 2'd2,
        CFG_DISORDER  = 2'd3
    } pid_cfg_idx_t;

    typedef enum logic [2:0] {
        ALU_DRAW = 3'b001,
        ALU_ADD  = 3'b010,
        ALU_DUE  = 3'b100
    } pid_alu_op_t;

    typedef struct packed {
        logic [0:0]  command;
        logic [31:0] time_now;
        logic [31:0] packet_descriptor;
        logic [15:0] draw_loss;
        logic [15:0] draw_disorder;
        logic [15:0] draw_duplicate;
    } pid_in_t;

    typedef struct packed {
        logic [31:0] packet_out;
        logic [0:0]  status;
        logic [0:0]  last_of_run;
    } pid_out_t;

    typedef struct packed {
        logic [31:0] desc;
        logic [31:0] rel_time;
    } pid_entry_t;

endpackage

`default_nettype wire

// ===== rtl/pid_in_if.sv =====
`default_nettype none

interface pid_in_if import pid_pkg::*; ();
    logic    valid;
    logic    ready;
    pid_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/pid_out_if.sv =====
`default_nettype none

interface pid_out_if import pid_pkg::*; ();
    logic     valid;
    logic     ready;
    pid_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/pid_alu.sv =====
`default_nettype none

// Shared adder: draw compare, release time sum, wrapped due test.
module pid_alu import pid_pkg::*;
(
    input  wire pid_alu_op_t op,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic [31:0]      sum,
    output logic             flag
);

    logic [32:0] x;
    logic [32:0] y;
    logic        sub;
    logic [32:0] res;
    logic [22:0] draw_scaled;
    logic [22:0] pct_scaled;

    // draw*100 = draw*64 + draw*32 + draw*4; pct*65535 = pct*65536 - pct
    assign draw_scaled = {1'b0, a[15:0], 6'b0} + {2'b0, a[15:0], 5'b0}
                       + {5'b0, a[15:0], 2'b0};
    assign pct_scaled  = {b[6:0], 16'b0} - {16'b0, b[6:0]};

    always_comb
    begin
        x   = {1'b0, a};
        y   = {1'b0, b};
        sub = 1'b0;
        unique case (op)
            ALU_DRAW:
            begin
                x   = {10'b0, draw_scaled};
                y   = {10'b0, pct_scaled};
                sub = 1'b1;
            end
            ALU_ADD:
            begin
                sub = 1'b0;
            end
            ALU_DUE:
            begin
                sub = 1'b1;
            end
            default:
            begin
                sub = 1'b0;
            end
        endcase
    end

    assign res = x + (y ^ {33{sub}}) + {32'b0, sub};
    assign sum = res[31:0];

    // Draw hit: the carry out (no borrow) of draw*100 - pct*65535; due test: the sign bit of a - b is clear
    always_comb
    begin
        unique case (op)
            ALU_DRAW: flag = res[32];
            ALU_DUE:  flag = ~res[31];
            default:  flag = res[32];
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/pid_ram.sv =====
`default_nettype none

// Ring storage: one write port, one read port with registered data.
module pid_ram import pid_pkg::*;
#(
    parameter int unsigned DEPTH = PID_QUEUE_DEPTH,
    parameter int unsigned IDX_W = $clog2(DEPTH)
)
(
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [IDX_W-1:0] waddr,
    input  wire pid_entry_t       wdata,
    input  wire logic             re,
    input  wire logic [IDX_W-1:0] raddr,
    output pid_entry_t            rdata
);

    pid_entry_t mem [DEPTH];
    pid_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Hold read data until the next read so a stalled check sees it stable
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/packet_impairment_delay_queue.sv =====
// Send word: loss draw, then duplicate draw; at or below the lag limit the copies go out at once, else
// release sum, disorder draw and push (loss, duplicate, release sum, disorder each take one pass of the shared adder).
// Tick word: each released entry takes a queue read, then a due test; a finish step sends the last one.
// One word is worked at a time; the result register lets the next word in while it waits.
// rst_n is asynchronous, active low: clears state, pointers, count, valid flags and config registers.
// Queue storage is not cleared; only entries covered by the count are ever read.
`default_nettype none

module packet_impairment_delay_queue import pid_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = PID_QUEUE_DEPTH
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [PID_CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [PID_CFG_DATA_W-1:0] cfg_data,
    pid_in_if.sink                         request,
    pid_out_if.source                      result
);

    localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_LOSS  = 13'b0000000000010,
        ST_DUP   = 13'b0000000000100,
        ST_EMIT1 = 13'b0000000001000,
        ST_EMIT2 = 13'b0000000010000,
        ST_REL   = 13'b0000000100000,
        ST_DIS   = 13'b0000001000000,
        ST_SWAP  = 13'b0000010000000,
        ST_PUSH1 = 13'b0000100000000,
        ST_PUSH2 = 13'b0001000000000,
        ST_T_RD  = 13'b0010000000000,
        ST_T_CHK = 13'b0100000000000,
        ST_T_FIN = 13'b1000000000000
    } state_t;

    // Configuration registers
    logic [15:0] lag_reg;
    logic [6:0]  loss_reg;
    logic [6:0]  dup_pct_reg;
    logic [6:0]  dis_pct_reg;

    // Sequencer state
    state_t                 state_reg, state_next;
    pid_in_t                word_reg, word_next;
    logic                   dup_reg, dup_next;
    logic [31:0]            rel_reg, rel_next;
    logic [31:0]            push_desc_reg, push_desc_next;
    logic [IDX_W-1:0]       head_reg, head_next;
    logic [IDX_W-1:0]       tail_reg, tail_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [PID_TAKEN_W-1:0] taken_reg, taken_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [31:0]            pend_desc_reg, pend_desc_next;

    // Result register
    logic     out_valid_reg;
    pid_out_t out_word_reg;
    logic     out_free;

    // Emit request from the sequencer into the result register
    logic        emit;
    logic [31:0] emit_desc;
    pid_status_t emit_status;
    logic        emit_last;

    // Shared adder
    pid_alu_op_t alu_op;
    logic [31:0] alu_a;
    logic [31:0] alu_b;
    logic [31:0] alu_sum;
    logic        alu_flag;

    // Ring storage ports
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    pid_entry_t       ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    pid_entry_t       ram_rdata;

    logic             full;
    logic [IDX_W-1:0] tail_prev;
    logic [IDX_W-1:0] tail_inc;
    logic [IDX_W-1:0] head_inc;

    pid_alu u_alu (
        .op   (alu_op),
        .a    (alu_a),
        .b    (alu_b),
        .sum  (alu_sum),
        .flag (alu_flag)
    );

    pid_ram #(
        .DEPTH (QUEUE_DEPTH),
        .IDX_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign tail_prev = (tail_reg == '0) ? IDX_W'(QUEUE_DEPTH - 1) : tail_reg - 1'b1;
    assign tail_inc  = (tail_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign head_inc  = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    assign out_free      = ~out_valid_reg | result.ready;
    assign request.ready = (state_reg == ST_IDLE);
    assign result.valid  = out_valid_reg;
    assign result.data   = out_word_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lag_reg     <= '0;
            loss_reg    <= '0;
            dup_pct_reg <= '0;
            dis_pct_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (pid_cfg_idx_t'(cfg_index))
                CFG_LAG:       lag_reg     <= cfg_data;
                CFG_LOSS:      loss_reg    <= cfg_data[6:0];
                CFG_DUPLICATE: dup_pct_reg <= cfg_data[6:0];
                CFG_DISORDER:  dis_pct_reg <= cfg_data[6:0];
                default:       lag_reg     <= lag_reg;
            endcase
        end
    end

    // Operand select for the shared adder, one use per state
    always_comb
    begin
        alu_op = ALU_DRAW;
        alu_a  = '0;
        alu_b  = '0;
        unique case (state_reg)
            ST_LOSS:
            begin
                alu_op = ALU_DRAW;
                alu_a  = {16'b0, word_reg.draw_loss};
                alu_b  = {25'b0, loss_reg};
            end
            ST_DUP:
            begin
                alu_op = ALU_DRAW;
                alu_a  = {16'b0, word_reg.draw_duplicate};
                alu_b  = {25'b0, dup_pct_reg};
            end
            ST_REL:
            begin
                alu_op = ALU_ADD;
                alu_a  = word_reg.time_now;
                alu_b  = {16'b0, lag_reg};
            end
            ST_DIS:
            begin
                alu_op = ALU_DRAW;
                alu_a  = {16'b0, word_reg.draw_disorder};
                alu_b  = {25'b0, dis_pct_reg};
            end
            ST_T_CHK:
            begin
                alu_op = ALU_DUE;
                alu_a  = word_reg.time_now;
                alu_b  = ram_rdata.rel_time;
            end
            default:
            begin
                alu_op = ALU_DRAW;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        word_next       = word_reg;
        dup_next        = dup_reg;
        rel_next        = rel_reg;
        push_desc_next  = push_desc_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        taken_next      = taken_reg;
        pend_valid_next = pend_valid_reg;
        pend_desc_next  = pend_desc_reg;
        emit            = 1'b0;
        emit_desc       = word_reg.packet_descriptor;
        emit_status     = STATUS_SENT;
        emit_last       = 1'b1;
        ram_we          = 1'b0;
        ram_waddr       = tail_reg;
        ram_wdata       = '{desc: push_desc_reg, rel_time: rel_reg};
        ram_re          = 1'b0;
        ram_raddr       = head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (request.valid)
                begin
                    word_next  = request.data;
                    taken_next = '0;
                    if (pid_cmd_t'(request.data.command) == CMD_TICK)
                    begin
                        state_next = ST_T_RD;
                    end
                    else
                    begin
                        state_next = ST_LOSS;
                    end
                end
            end

            // Drop the packet on a loss hit
            ST_LOSS:
            begin
                state_next = alu_flag ? ST_IDLE : ST_DUP;
            end

            ST_DUP:
            begin
                dup_next   = alu_flag;
                state_next = (lag_reg <= PID_LAG_IMMEDIATE_MAX) ? ST_EMIT1 : ST_REL;
            end

            ST_EMIT1:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_last  = ~dup_reg;
                    state_next = dup_reg ? ST_EMIT2 : ST_IDLE;
                end
            end

            ST_EMIT2:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_REL:
            begin
                rel_next   = alu_sum;
                state_next = ST_DIS;
            end

            // On a disorder hit with a non-empty queue, fetch the tail entry to swap descriptors
            ST_DIS:
            begin
                if (alu_flag && (count_reg != '0))
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = tail_prev;
                    state_next = ST_SWAP;
                end
                else
                begin
                    push_desc_next = word_reg.packet_descriptor;
                    state_next     = ST_PUSH1;
                end
            end

            // Tail slot keeps its release time and takes the new descriptor
            ST_SWAP:
            begin
                push_desc_next = ram_rdata.desc;
                ram_we         = 1'b1;
                ram_waddr      = tail_prev;
                ram_wdata      = '{desc: word_reg.packet_descriptor,
                                   rel_time: ram_rdata.rel_time};
                state_next     = ST_PUSH1;
            end

            ST_PUSH1:
            begin
                if (!full)
                begin
                    ram_we     = 1'b1;
                    tail_next  = tail_inc;
                    count_next = count_reg + 1'b1;
                    state_next = dup_reg ? ST_PUSH2 : ST_IDLE;
                end
                else if (out_free)
                begin
                    // A full queue stays full, so a copy that follows drops too
                    emit        = 1'b1;
                    emit_desc   = push_desc_reg;
                    emit_status = STATUS_DROPPED;
                    emit_last   = ~dup_reg;
                    state_next  = dup_reg ? ST_PUSH2 : ST_IDLE;
                end
            end

            ST_PUSH2:
            begin
                if (!full)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = '{desc: word_reg.packet_descriptor, rel_time: rel_reg};
                    tail_next  = tail_inc;
                    count_next = count_reg + 1'b1;
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    emit        = 1'b1;
                    emit_status = STATUS_DROPPED;
                    state_next  = ST_IDLE;
                end
            end

            // Read the head while entries remain and the burst is not used up
            ST_T_RD:
            begin
                if ((count_reg != '0) && (taken_reg < PID_TAKEN_W'(PID_MAX_RESULTS)))
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = head_reg;
                    state_next = ST_T_CHK;
                end
                else
                begin
                    state_next = pend_valid_reg ? ST_T_FIN : ST_IDLE;
                end
            end

            // A due head becomes the pending word; the one before it goes out
            ST_T_CHK:
            begin
                if (alu_flag)
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        emit            = pend_valid_reg;
                        emit_desc       = pend_desc_reg;
                        emit_last       = 1'b0;
                        pend_valid_next = 1'b1;
                        pend_desc_next  = ram_rdata.desc;
                        taken_next      = taken_reg + 1'b1;
                        head_next       = head_inc;
                        count_next      = count_reg - 1'b1;
                        state_next      = ST_T_RD;
                    end
                end
                else
                begin
                    state_next = pend_valid_reg ? ST_T_FIN : ST_IDLE;
                end
            end

            ST_T_FIN:
            begin
                if (out_free)
                begin
                    emit            = 1'b1;
                    emit_desc       = pend_desc_reg;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            taken_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            taken_reg      <= taken_next;
            pend_valid_reg <= pend_valid_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        word_reg      <= word_next;
        dup_reg       <= dup_next;
        rel_reg       <= rel_next;
        push_desc_reg <= push_desc_next;
        pend_desc_reg <= pend_desc_next;
        if (emit)
        begin
            out_word_reg <= '{packet_out: emit_desc, status: emit_status,
                              last_of_run: emit_last};
        end
    end

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
        taken_reg <= PID_TAKEN_W'(PID_MAX_RESULTS))
        else $error("tick burst above result limit");

    a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (emit_status == STATUS_DROPPED)) |-> full)
        else $error("drop status with room in queue");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending tick word left behind");

    a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("result register overwritten");

endmodule

`default_nettype wire
